/* rtl/dnr_pkg.sv */
// shared widths, register codes and types for the decaying noise resonator
package dnr_pkg;

  localparam int NOISE_W    = 16;
  localparam int SAMPLE_W   = 24;
  localparam int LEVEL_W    = 20;
  localparam int DECAY_W    = 16;
  localparam int FB1_W      = 18;
  localparam int FB2_W      = 17;
  localparam int LEN_W      = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 20;

  localparam logic [LEN_W-1:0]   MAX_LENGTH        = 16'd20000;
  localparam logic [LEVEL_W-1:0] START_LEVEL_RESET = 20'd65536;
  localparam logic [DECAY_W-1:0] LEVEL_DECAY_RESET = 16'd65535;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FEEDBACK_ONE = 3'd0,
    REG_FEEDBACK_TWO = 3'd1,
    REG_START_LEVEL  = 3'd2,
    REG_LEVEL_DECAY  = 3'd3,
    REG_GRAIN_LENGTH = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic signed [FB1_W-1:0] feedback_one;
    logic [FB2_W-1:0]        feedback_two;
    logic [DECAY_W-1:0]      level_decay;
  } coef_t;

endpackage

/* rtl/dnr_datapath.sv */
// resonator arithmetic: scaled noise, two feedback terms, saturation, level decay
module dnr_datapath (
  input  logic signed [dnr_pkg::NOISE_W-1:0]  noise,
  input  logic [dnr_pkg::LEVEL_W-1:0]         level,
  input  logic signed [dnr_pkg::SAMPLE_W-1:0] prev_out,
  input  logic signed [dnr_pkg::SAMPLE_W-1:0] prev_prev_out,
  input  dnr_pkg::coef_t                      coef,
  output logic signed [dnr_pkg::SAMPLE_W-1:0] sample,
  output logic [dnr_pkg::LEVEL_W-1:0]         level_next
);
  import dnr_pkg::*;

  localparam int EP_W  = NOISE_W + LEVEL_W + 1;
  localparam int T1P_W = FB1_W + SAMPLE_W;
  localparam int T2P_W = FB2_W + 1 + SAMPLE_W;
  localparam int ACC_W = SAMPLE_W + 4;
  localparam int LP_W  = LEVEL_W + DECAY_W;

  logic signed [EP_W-1:0]  exc_prod;
  logic signed [T1P_W-1:0] t1_prod;
  logic signed [T2P_W-1:0] t2_prod;
  logic signed [EP_W-1:0]  exc_rnd;
  logic signed [T1P_W-1:0] t1_rnd;
  logic signed [T2P_W-1:0] t2_rnd;
  logic signed [ACC_W-1:0] acc;
  logic [LP_W-1:0]         level_prod;

  localparam logic signed [ACC_W-1:0] OUT_MAX = ACC_W'(8388607);
  localparam logic signed [ACC_W-1:0] OUT_MIN = -ACC_W'(8388608);

  assign exc_prod = EP_W'(noise) * EP_W'($signed({1'b0, level}));
  assign t1_prod  = T1P_W'(coef.feedback_one) * T1P_W'(prev_out);
  assign t2_prod  = T2P_W'($signed({1'b0, coef.feedback_two})) * T2P_W'(prev_prev_out);

  // round half up then floor
  assign exc_rnd = (exc_prod + EP_W'(32768)) >>> 16;
  assign t1_rnd  = (t1_prod + T1P_W'(32768)) >>> 16;
  assign t2_rnd  = (t2_prod + T2P_W'(32768)) >>> 16;

  assign acc = ACC_W'(exc_rnd) - ACC_W'(t1_rnd) - ACC_W'(t2_rnd);

  always_comb begin
    if (acc > OUT_MAX) begin
      sample = OUT_MAX[SAMPLE_W-1:0];
    end else if (acc < OUT_MIN) begin
      sample = OUT_MIN[SAMPLE_W-1:0];
    end else begin
      sample = acc[SAMPLE_W-1:0];
    end
  end

  assign level_prod = LP_W'(level) * LP_W'(coef.level_decay);
  assign level_next = level_prod[LP_W-1:DECAY_W];

endmodule

/* rtl/decaying_noise_resonator_unit.sv */
// top level of the decaying noise resonator grain generator
// Takes one noise transaction per cycle while item_stall is low, and answers a running grain
// with one sample transaction through the input register, then the result register. The resonator
// state updates in the single stage between them, so a new transaction can enter while its
// predecessor's sample waits in the result register; the only slowdown comes from stall on the result
// channel. Configuration writes are always ready and take effect on the next item.
module decaying_noise_resonator_unit (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic signed [dnr_pkg::NOISE_W-1:0]    noise,
  input  logic                                  restart,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic signed [dnr_pkg::SAMPLE_W-1:0]   sample,
  output logic                                  last,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [dnr_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [dnr_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import dnr_pkg::*;

  coef_t                      coef;
  logic [LEVEL_W-1:0]         start_level;
  logic [LEN_W-1:0]           grain_length;

  logic                       s1_valid;
  logic signed [NOISE_W-1:0]  s1_noise;
  logic                       s1_restart;

  logic signed [SAMPLE_W-1:0] prev_out;
  logic signed [SAMPLE_W-1:0] prev_prev_out;
  logic [LEVEL_W-1:0]         level;
  logic [LEN_W-1:0]           sample_count;
  logic                       active;

  logic [LEN_W-1:0]           eff_length;
  logic                       cur_active;
  logic [LEN_W-1:0]           cur_count;
  logic [LEVEL_W-1:0]         cur_level;
  logic signed [SAMPLE_W-1:0] cur_prev;
  logic signed [SAMPLE_W-1:0] cur_prev_prev;
  logic [LEN_W-1:0]           count_next;
  logic                       emit;
  logic                       is_last;
  logic                       fire;
  logic signed [SAMPLE_W-1:0] y;
  logic [LEVEL_W-1:0]         level_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef.feedback_one <= '0;
      coef.feedback_two <= '0;
      coef.level_decay  <= LEVEL_DECAY_RESET;
      start_level       <= START_LEVEL_RESET;
      grain_length      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FEEDBACK_ONE: coef.feedback_one <= cfg_data[FB1_W-1:0];
        REG_FEEDBACK_TWO: coef.feedback_two <= cfg_data[FB2_W-1:0];
        REG_START_LEVEL:  start_level       <= cfg_data[LEVEL_W-1:0];
        REG_LEVEL_DECAY:  coef.level_decay  <= cfg_data[DECAY_W-1:0];
        REG_GRAIN_LENGTH: grain_length      <= cfg_data[LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign fire       = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item_valid && !item_stall) begin
      s1_valid <= 1'b1;
    end else if (fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && !item_stall) begin
      s1_noise   <= noise;
      s1_restart <= restart;
    end
  end

  assign eff_length    = (grain_length > MAX_LENGTH) ? MAX_LENGTH : grain_length;
  assign cur_active    = s1_restart ? (eff_length != '0) : active;
  assign cur_count     = s1_restart ? '0 : sample_count;
  assign cur_level     = s1_restart ? start_level : level;
  assign cur_prev      = s1_restart ? '0 : prev_out;
  assign cur_prev_prev = s1_restart ? '0 : prev_prev_out;
  assign emit          = cur_active && (cur_count < eff_length);
  assign count_next    = cur_count + LEN_W'(1);
  assign is_last       = count_next >= eff_length;

  dnr_datapath u_datapath (
    .noise         (s1_noise),
    .level         (cur_level),
    .prev_out      (cur_prev),
    .prev_prev_out (cur_prev_prev),
    .coef          (coef),
    .sample        (y),
    .level_next    (level_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_out      <= '0;
      prev_prev_out <= '0;
      level         <= '0;
      sample_count  <= '0;
      active        <= 1'b0;
    end else if (fire) begin
      active <= emit && !is_last;
      if (emit) begin
        prev_out      <= y;
        prev_prev_out <= cur_prev;
        level         <= level_next;
        sample_count  <= count_next;
      end else begin
        prev_out      <= cur_prev;
        prev_prev_out <= cur_prev_prev;
        level         <= cur_level;
        sample_count  <= cur_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire && emit) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      sample <= y;
      last   <= is_last;
    end
  end

`ifndef SYNTHESIS
  a_last_ends_grain: assert property (@(posedge clk) disable iff (rst)
    (fire && emit && is_last) |=> !active)
    else $error("grain still active after its final sample");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    active |-> (sample_count < MAX_LENGTH))
    else $error("sample count beyond maximum grain length while active");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |-> !(fire && emit))
    else $error("new sample computed while result register is held");
`endif

endmodule

/* sim/tb_decaying_noise_resonator_unit.sv */
// testbench for the decaying noise resonator: queued grains, random handshakes, sample checks
module tb_decaying_noise_resonator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import dnr_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int RANDOM_TICKS = 500;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_GRAIN_TICKS = 24;

  typedef struct {
    logic signed [NOISE_W-1:0] noise_val;
    logic                      restart_val;
  } tick_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_val;
    logic                       last_val;
  } grain_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_stall;
  logic signed [NOISE_W-1:0] noise = '0;
  logic restart = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] sample;
  logic last;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor copy of the registers
  logic signed [FB1_W-1:0] fb_one = '0;
  logic [FB2_W-1:0] fb_two = '0;
  logic [LEVEL_W-1:0] level_init = START_LEVEL_RESET;
  logic [DECAY_W-1:0] decay_factor = LEVEL_DECAY_RESET;
  logic [LEN_W-1:0] grain_len = '0;

  // predictor copy of the grain state
  logic signed [SAMPLE_W-1:0] y_last = '0;
  logic signed [SAMPLE_W-1:0] y_older = '0;
  logic [LEVEL_W-1:0] gain = '0;
  logic [LEN_W-1:0] count = '0;
  logic running = 1'b0;

  tick_t pending_ticks[$];
  grain_out_t expected_samples[$];
  int error_count = 0;
  int burst_left = 0;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_tick = 0;

  decaying_noise_resonator_unit dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .noise(noise),
    .restart(restart),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .sample(sample),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint round16(longint x);
    return (x + 32768) >>> 16;
  endfunction

  function automatic bit resonate(input logic signed [NOISE_W-1:0] n_in, input logic rs,
                                  output grain_out_t res);
    logic [LEN_W-1:0] span;
    longint acc;
    logic signed [SAMPLE_W-1:0] y;
    logic [LEVEL_W+DECAY_W-1:0] prod;
    span = (grain_len > MAX_LENGTH) ? MAX_LENGTH : grain_len;
    res = '0;
    if (rs) begin
      y_last = '0;
      y_older = '0;
      gain = level_init;
      count = '0;
      running = (span != 0);
    end
    if (!running) return 1'b0;
    if (count >= span) begin
      running = 1'b0;
      return 1'b0;
    end
    acc = round16(longint'(n_in) * longint'(gain))
        - round16(longint'(fb_one) * longint'(y_last))
        - round16(longint'(fb_two) * longint'(y_older));
    if (acc > 8388607) y = 24'sh7FFFFF;
    else if (acc < -8388608) y = 24'sh800000;
    else y = acc[SAMPLE_W-1:0];
    prod = gain * decay_factor;
    gain = prod[LEVEL_W+DECAY_W-1:DECAY_W];
    y_older = y_last;
    y_last = y;
    count = count + 1'b1;
    res.sample_val = y;
    res.last_val = (count >= span);
    if (res.last_val) running = 1'b0;
    return 1'b1;
  endfunction

  function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
    case (idx)
      REG_FEEDBACK_ONE: fb_one = d[FB1_W-1:0];
      REG_FEEDBACK_TWO: fb_two = d[FB2_W-1:0];
      REG_START_LEVEL:  level_init = d[LEVEL_W-1:0];
      REG_LEVEL_DECAY:  decay_factor = d[DECAY_W-1:0];
      REG_GRAIN_LENGTH: grain_len = d[LEN_W-1:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    while (pending_ticks.size() != 0 || item_valid || expected_samples.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic void push_tick(logic signed [NOISE_W-1:0] n, logic rs);
    pending_ticks.push_back('{noise_val: n, restart_val: rs});
  endfunction

  function automatic logic signed [NOISE_W-1:0] pick_noise();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      default: return NOISE_W'($urandom);
    endcase
  endfunction

  // random register set; unstable resonators saturate, stable ones ring
  task automatic pick_config(output int span_hint);
    logic [CFG_DATA_W-1:0] d;
    int fb2_v;
    int bound;
    int fb1_v;
    int len_v;
    case ($urandom_range(0, 7))
      0: fb2_v = 0;
      1: fb2_v = 65536;
      2, 3: fb2_v = $urandom_range(0, 65536);
      default: fb2_v = $urandom_range(30000, 65000);
    endcase
    bound = 65535 + fb2_v;
    if (bound > 131071) bound = 131071;
    case ($urandom_range(0, 7))
      0: fb1_v = -131072;
      1: fb1_v = 131071;
      2: fb1_v = $urandom;
      default: fb1_v = int'($urandom_range(0, 2 * bound)) - bound;
    endcase
    d = CFG_DATA_W'($urandom);
    d[FB1_W-1:0] = fb1_v[FB1_W-1:0];
    write_reg(REG_FEEDBACK_ONE, d);
    d = CFG_DATA_W'($urandom);
    d[FB2_W-1:0] = fb2_v[FB2_W-1:0];
    write_reg(REG_FEEDBACK_TWO, d);
    case ($urandom_range(0, 7))
      0: d = '0;
      1: d = '1;
      default: d = CFG_DATA_W'($urandom);
    endcase
    write_reg(REG_START_LEVEL, d);
    d = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 7))
      0: d[DECAY_W-1:0] = '0;
      1: d[DECAY_W-1:0] = '1;
      2, 3: d[DECAY_W-1:0] = DECAY_W'($urandom);
      default: d[DECAY_W-1:0] = DECAY_W'($urandom_range(50000, 65535));
    endcase
    write_reg(REG_LEVEL_DECAY, d);
    case ($urandom_range(0, 9))
      0: len_v = 0;
      1: len_v = $urandom_range(0, 65535);
      default: len_v = $urandom_range(1, 24);
    endcase
    d = CFG_DATA_W'($urandom);
    d[LEN_W-1:0] = len_v[LEN_W-1:0];
    write_reg(REG_GRAIN_LENGTH, d);
    if ($urandom_range(0, 3) == 0)
      write_reg(CFG_INDEX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                CFG_DATA_W'($urandom));
    span_hint = (len_v > 40) ? 40 : len_v;
  endtask

  // item driver: bursts of transactions with random gaps
  always @(posedge clk) begin : drive_items
    tick_t cur;
    grain_out_t outcome;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        if (resonate(noise, restart, outcome)) expected_samples.push_back(outcome);
      end
      if (!item_valid || !item_stall) begin
        if (gap_left > 0 || pending_ticks.size() == 0) begin
          item_valid <= 1'b0;
          noise <= NOISE_W'($urandom);
          if (gap_left > 0) gap_left <= gap_left - 1;
        end else begin
          cur = pending_ticks.pop_front();
          item_valid <= 1'b1;
          noise <= cur.noise_val;
          restart <= cur.restart_val;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 16);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // result monitor and stall pattern
  always @(posedge clk) begin : watch_samples
    grain_out_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_samples.size() == 0) begin
          report_mismatch("sample without expectation", sample, 0);
        end else begin
          want = expected_samples.pop_front();
          if (sample !== want.sample_val) report_mismatch("sample", sample, want.sample_val);
          if (last !== want.last_val) report_mismatch("last", last, want.last_val);
        end
      end
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 63) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 1) == 0);
        2: result_stall <= ($urandom_range(0, 3) != 0);
        default: result_stall <= (stall_tick % 3 == 0);
      endcase
    end
  end

  initial begin : stimulus
    int span_hint;
    int extra;
    int random_ticks;
    random_ticks = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // zero length after reset: no grain, idle input ignored
    push_tick(16'sh7FFF, 1'b1);
    push_tick(16'sh8000, 1'b0);
    settle();

    // full level, noise extremes, tick past the end of the grain
    write_reg(REG_FEEDBACK_ONE, '0);
    write_reg(REG_FEEDBACK_TWO, '0);
    write_reg(REG_START_LEVEL, 20'hFFFFF);
    write_reg(REG_LEVEL_DECAY, 20'h0FFFF);
    write_reg(REG_GRAIN_LENGTH, 20'd4);
    push_tick(16'sh7FFF, 1'b1);
    push_tick(16'sh8000, 1'b0);
    push_tick(16'sh0000, 1'b0);
    push_tick(-16'sd1, 1'b0);
    push_tick(16'sh0001, 1'b0);
    settle();

    // runaway resonator into both saturation limits, restart mid-grain
    write_reg(REG_FEEDBACK_ONE, 20'h20000);
    write_reg(REG_GRAIN_LENGTH, 20'd12);
    push_tick(16'sh8000, 1'b1);
    repeat (4) push_tick(16'sh8000, 1'b0);
    push_tick(16'sh7FFF, 1'b1);
    repeat (4) push_tick(16'sh7FFF, 1'b0);
    settle();

    // opposite coefficient extremes, level gone after one sample
    write_reg(REG_FEEDBACK_ONE, 20'h1FFFF);
    write_reg(REG_FEEDBACK_TWO, 20'h10000);
    write_reg(REG_LEVEL_DECAY, '0);
    push_tick(16'sh7FFF, 1'b1);
    repeat (3) push_tick(16'sh7FFF, 1'b0);
    settle();

    // length lowered below the running count ends the grain silently
    write_reg(REG_FEEDBACK_ONE, '0);
    write_reg(REG_FEEDBACK_TWO, '0);
    write_reg(REG_START_LEVEL, 20'h10000);
    write_reg(REG_LEVEL_DECAY, 20'h0FFFF);
    write_reg(REG_GRAIN_LENGTH, 20'd10);
    push_tick(16'sh4000, 1'b1);
    repeat (4) push_tick(pick_noise(), 1'b0);
    settle();
    write_reg(REG_GRAIN_LENGTH, 20'd3);
    write_reg(REG_SPARE_LO, 20'hFFFFF);
    write_reg(REG_SPARE_HI, CFG_DATA_W'($urandom));
    push_tick(16'sh7FFF, 1'b0);
    push_tick(16'sh7FFF, 1'b0);
    settle();

    while (random_ticks < RANDOM_TICKS) begin
      pick_config(span_hint);
      repeat ($urandom_range(2, 4)) begin
        push_tick(pick_noise(), 1'b1);
        extra = $urandom_range(0, span_hint + 2);
        repeat (extra) push_tick(pick_noise(), $urandom_range(0, 19) == 0);
        random_ticks += 1 + extra;
        if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) push_tick(pick_noise(), 1'b0);
      end
      settle();
    end

    // length above the maximum still runs a long grain
    write_reg(REG_FEEDBACK_ONE, '0);
    write_reg(REG_FEEDBACK_TWO, '0);
    write_reg(REG_START_LEVEL, 20'h10000);
    write_reg(REG_LEVEL_DECAY, 20'h0FFFF);
    write_reg(REG_GRAIN_LENGTH, 20'h0FFFF);
    push_tick(pick_noise(), 1'b1);
    repeat (LONG_GRAIN_TICKS) push_tick(pick_noise(), 1'b0);
    settle();

    if (error_count == 0) $display("tb_decaying_noise_resonator_unit: clean");
    else $display("tb_decaying_noise_resonator_unit: errors");
    $finish;
  end

  initial begin : watchdog
    #5000000;
    $display("tb_decaying_noise_resonator_unit: errors");
    $finish;
  end

endmodule
